// ===== hw/rtl/sadz_pkg.sv =====
// Shared types and constants for the strip ADC digitizer with zero suppression.
// No dependencies.
package sadz_pkg;

	localparam int unsigned APB_AW = 4;
	localparam int unsigned APB_DW = 32;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_ADC_BITS = 2'd0;
	localparam logic [1:0] REG_GAIN     = 2'd1;
	localparam logic [1:0] REG_CUT      = 2'd2;

	localparam logic [4:0]  ADC_BITS_RST = 5'd10;
	localparam logic [31:0] GAIN_RST     = 32'd9544;
	localparam logic [15:0] CUT_RST      = 16'd768;

	localparam int unsigned ID_W     = 10;
	localparam int unsigned VAL_W    = 24;
	localparam int unsigned PED_W    = 23;
	localparam int unsigned SIG_W    = 23;
	localparam int unsigned DIGIT_W  = 16;
	localparam int unsigned S_DATA_W = 80;
	localparam int unsigned M_DATA_W = 72;

	typedef struct packed {
		logic [4:0]  adc_bits;
		logic [31:0] gain;
		logic [15:0] cut;
	} cfg_t;

	// per-stage load enables
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en4;
	} pipe_en_t;

endpackage

// ===== hw/rtl/sadz_cfg.sv =====
// APB register file: ADC resolution, Q0.32 gain and Q8.8 cut factor.
// Depends on sadz_pkg.
module sadz_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sadz_pkg::APB_AW-1:0]   paddr,
	input  logic [sadz_pkg::APB_DW-1:0]   pwdata,
	output logic [sadz_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output sadz_pkg::cfg_t                cfg
);
	import sadz_pkg::*;

	logic [4:0]  adc_bits_q;
	logic [31:0] gain_q;
	logic [15:0] cut_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adc_bits_q <= ADC_BITS_RST;
			gain_q     <= GAIN_RST;
			cut_q      <= CUT_RST;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_ADC_BITS: adc_bits_q <= pwdata[4:0];
				REG_GAIN:     gain_q     <= pwdata;
				REG_CUT:      cut_q      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ADC_BITS: prdata = {27'd0, adc_bits_q};
			REG_GAIN:     prdata = gain_q;
			REG_CUT:      prdata = {16'd0, cut_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg = '{adc_bits: adc_bits_q, gain: gain_q, cut: cut_q};

endmodule

// ===== hw/rtl/sadz_mult.sv =====
// First pipeline stage: charge magnitude, pedestal and sigma times the gain.
// Depends on sadz_pkg.
module sadz_mult #(
	parameter int unsigned STRIP_ID_BITS = 10
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic [31:0]                   gain,
	input  logic [sadz_pkg::ID_W-1:0]     strip_number,
	input  logic [sadz_pkg::VAL_W-1:0]    analog_value,
	input  logic [sadz_pkg::PED_W-1:0]    pedestal_e,
	input  logic [sadz_pkg::SIG_W-1:0]    sigma_e,
	input  logic                          last_strip,
	output logic [sadz_pkg::ID_W-1:0]     id_s1,
	output logic                          neg_s1,
	output logic [55:0]                   prod_val_s1,
	output logic [54:0]                   prod_ped_s1,
	output logic [54:0]                   prod_sig_s1,
	output logic                          last_s1
);
	import sadz_pkg::*;

	localparam logic [ID_W-1:0] ID_MASK = (STRIP_ID_BITS >= ID_W) ? {ID_W{1'b1}} :
		ID_W'((1 << STRIP_ID_BITS) - 1);

	logic [VAL_W-1:0] mag;

	// most negative code negates to itself, which is the right magnitude unsigned
	assign mag = analog_value[VAL_W-1] ? (~analog_value + VAL_W'(1)) : analog_value;

	always_ff @(posedge clk) begin
		if (load) begin
			id_s1       <= strip_number & ID_MASK;
			neg_s1      <= analog_value[VAL_W-1];
			prod_val_s1 <= 56'(mag) * 56'(gain);
			prod_ped_s1 <= 55'(pedestal_e) * 55'(gain);
			prod_sig_s1 <= 55'(sigma_e) * 55'(gain);
			last_s1     <= last_strip;
		end
	end

endmodule

// ===== hw/rtl/sadz_scale.sv =====
// Stages two to four: cut multiply, rounding, top-code clamps and keep decision.
// Depends on sadz_pkg.
module sadz_scale #(
	parameter int unsigned MAX_ADC_BITS = 16
) (
	input  logic                          clk,
	input  sadz_pkg::pipe_en_t            en,
	input  sadz_pkg::cfg_t                cfg,
	input  logic [sadz_pkg::ID_W-1:0]     id_s1,
	input  logic                          neg_s1,
	input  logic [55:0]                   prod_val_s1,
	input  logic [54:0]                   prod_ped_s1,
	input  logic [54:0]                   prod_sig_s1,
	input  logic                          last_s1,
	output logic [sadz_pkg::ID_W-1:0]     id_s4,
	output logic [sadz_pkg::VAL_W-1:0]    digit_s4,
	output logic [MAX_ADC_BITS-1:0]       ped_s4,
	output logic [MAX_ADC_BITS-1:0]       th_s4,
	output logic                          keep_s4,
	output logic                          last_s4
);
	import sadz_pkg::*;

	localparam int unsigned CW = ((MAX_ADC_BITS > VAL_W) ? MAX_ADC_BITS : VAL_W) + 1;

	logic [4:0]              bits_sat;
	logic [MAX_ADC_BITS-1:0] top;
	logic [VAL_W-1:0]        dmag;
	logic [VAL_W-1:0]        digit_raw;
	logic [55:0]             ped_sum;
	logic [VAL_W-1:0]        ped_raw;
	logic [71:0]             th_sum;
	logic [31:0]             th_raw;

	logic [ID_W-1:0]         id_s2, id_s3;
	logic                    last_s2, last_s3;
	logic [VAL_W-1:0]        digit_s2, digit_s3;
	logic [MAX_ADC_BITS-1:0] ped_s2, ped_s3;
	logic [70:0]             prod_th_s2;
	logic [MAX_ADC_BITS-1:0] th_s3;

	assign bits_sat = (cfg.adc_bits > 5'(MAX_ADC_BITS)) ? 5'(MAX_ADC_BITS) : cfg.adc_bits;
	assign top      = MAX_ADC_BITS'((CW'(1) << bits_sat) - CW'(1));

	// stage 2: truncated charge digit, rounded pedestal, sigma*gain*cut
	assign dmag      = prod_val_s1[55:32];
	assign digit_raw = neg_s1 ? (~dmag + VAL_W'(1)) : dmag;
	assign ped_sum   = {1'b0, prod_ped_s1} + 56'h0000_0080_0000_00;
	assign ped_raw   = ped_sum[55:32];

	always_ff @(posedge clk) begin
		if (en.en2) begin
			id_s2      <= id_s1;
			last_s2    <= last_s1;
			digit_s2   <= ($signed({{(CW-VAL_W){digit_raw[VAL_W-1]}}, digit_raw}) >
				$signed(CW'(top))) ? VAL_W'(top) : digit_raw;
			ped_s2     <= (CW'(ped_raw) > CW'(top)) ? top : MAX_ADC_BITS'(ped_raw);
			prod_th_s2 <= 71'(prod_sig_s1) * 71'(cfg.cut);
		end
	end

	// stage 3: round half up at bit 40 and clamp the threshold
	assign th_sum = {1'b0, prod_th_s2} + (72'd1 << 39);
	assign th_raw = th_sum[71:40];

	always_ff @(posedge clk) begin
		if (en.en3) begin
			id_s3    <= id_s2;
			last_s3  <= last_s2;
			digit_s3 <= digit_s2;
			ped_s3   <= ped_s2;
			th_s3    <= (th_raw > 32'(top)) ? top : MAX_ADC_BITS'(th_raw);
		end
	end

	// stage 4: keep when the signed digit is strictly above the threshold
	always_ff @(posedge clk) begin
		if (en.en4) begin
			id_s4    <= id_s3;
			last_s4  <= last_s3;
			digit_s4 <= digit_s3;
			ped_s4   <= ped_s3;
			th_s4    <= th_s3;
			keep_s4  <= $signed({{(CW-VAL_W){digit_s3[VAL_W-1]}}, digit_s3}) >
				$signed(CW'(th_s3));
		end
	end

endmodule

// ===== hw/rtl/strip_adc_digitize_zero_suppress_core.sv =====
// Top level of the strip ADC digitizer with zero suppression.
// Depends on sadz_pkg, sadz_cfg, sadz_mult and sadz_scale.

// Each input item is one detector strip (charge, pedestal and noise sigma in
// electrons). The block converts them to ADC counts with the Q0.32 gain
// register: the charge truncated toward zero, the pedestal rounded, and the
// threshold as sigma * gain * Q8.8 cut rounded once; all are clamped above at
// the top code 2^min(adc_bits, MAX_ADC_BITS) - 1, and the strip is marked
// kept (m_tuser) when its digit is strictly above its threshold. Throughput
// is one item per clock unless m_tready stalls the output; the four register
// stages (gain multiplies, cut multiply and charge/pedestal clamp, threshold
// rounding and clamp, keep compare) each hold their item independently, so
// the stages behind a stalled output keep filling. The user must write the
// registers via APB only while no item is in flight; the block does not check.
module strip_adc_digitize_zero_suppress_core #(
	parameter int unsigned MAX_ADC_BITS  = 16,
	parameter int unsigned STRIP_ID_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sadz_pkg::APB_AW-1:0]     paddr,
	input  logic [sadz_pkg::APB_DW-1:0]     pwdata,
	output logic [sadz_pkg::APB_DW-1:0]     prdata,
	output logic                            pready,
	// strip input
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// strip_number[9:0], analog_value[33:10], pedestal_e[56:34], sigma_e[79:57]
	input  logic [sadz_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic                            s_tlast,  // last_strip
	// digit output
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// strip_id[9:0], digit_value[33:10], pedestal_digit[49:34],
	// threshold_digit[65:50], zero pad[71:66]
	output logic [sadz_pkg::M_DATA_W-1:0]   m_tdata,
	output logic                            m_tuser,  // keep
	output logic                            m_tlast   // last_out
);
	import sadz_pkg::*;

	cfg_t     cfg;
	pipe_en_t en;
	logic     v_s1, v_s2, v_s3, v_s4;

	logic [ID_W-1:0]         id_s1, id_s4;
	logic                    neg_s1, last_s1, last_s4, keep_s4;
	logic [55:0]             prod_val_s1;
	logic [54:0]             prod_ped_s1, prod_sig_s1;
	logic [VAL_W-1:0]        digit_s4;
	logic [MAX_ADC_BITS-1:0] ped_s4, th_s4;

	// a stage loads when empty or when its item moves on
	assign en.en4 = ~v_s4 | m_tready;
	assign en.en3 = ~v_s3 | en.en4;
	assign en.en2 = ~v_s2 | en.en3;
	assign en.en1 = ~v_s1 | en.en2;
	assign s_tready = en.en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.en1) v_s1 <= s_tvalid;
			if (en.en2) v_s2 <= v_s1;
			if (en.en3) v_s3 <= v_s2;
			if (en.en4) v_s4 <= v_s3;
		end
	end

	sadz_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sadz_mult #(
		.STRIP_ID_BITS (STRIP_ID_BITS)
	) u_mult (
		.clk          (clk),
		.load         (en.en1),
		.gain         (cfg.gain),
		.strip_number (s_tdata[9:0]),
		.analog_value (s_tdata[33:10]),
		.pedestal_e   (s_tdata[56:34]),
		.sigma_e      (s_tdata[79:57]),
		.last_strip   (s_tlast),
		.id_s1        (id_s1),
		.neg_s1       (neg_s1),
		.prod_val_s1  (prod_val_s1),
		.prod_ped_s1  (prod_ped_s1),
		.prod_sig_s1  (prod_sig_s1),
		.last_s1      (last_s1)
	);

	sadz_scale #(
		.MAX_ADC_BITS (MAX_ADC_BITS)
	) u_scale (
		.clk         (clk),
		.en          (en),
		.cfg         (cfg),
		.id_s1       (id_s1),
		.neg_s1      (neg_s1),
		.prod_val_s1 (prod_val_s1),
		.prod_ped_s1 (prod_ped_s1),
		.prod_sig_s1 (prod_sig_s1),
		.last_s1     (last_s1),
		.id_s4       (id_s4),
		.digit_s4    (digit_s4),
		.ped_s4      (ped_s4),
		.th_s4       (th_s4),
		.keep_s4     (keep_s4),
		.last_s4     (last_s4)
	);

	assign m_tvalid = v_s4;
	assign m_tdata  = {6'd0, DIGIT_W'(th_s4), DIGIT_W'(ped_s4), digit_s4, id_s4};
	assign m_tuser  = keep_s4;
	assign m_tlast  = last_s4;

endmodule
